// ----- design/mrrb_pkg.sv -----
// shared types and constants for the memory request reorder buffer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mrrb_pkg;

  // default geometry
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 8;

  // fixed field widths
  localparam int ID_W    = 8;
  localparam int ADDR_W  = 64;
  localparam int DATA_W  = 64;
  localparam int DELAY_W = 16;
  localparam int TICK_W  = 32;
  localparam int CAP_W   = 5;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;

  // entry life cycle
  typedef enum logic [1:0] {
    ST_UNSENT    = 2'd0,
    ST_SENT      = 2'd1,
    ST_RESPONDED = 2'd2
  } status_e;

  // entry contents handed between neighboring cells (id travels apart)
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic               posted;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [TICK_W-1:0]  ready_time;
  } entry_t;

  // per-cell action
  typedef struct packed {
    logic shift;
    logic load;
    logic mark_sent;
    logic record;
  } cell_ctl_t;

  // per-cell status seen by the sequencer
  typedef struct packed {
    logic valid;
    logic unsent;
    logic sent;
    logic responded;
    logic hit;
  } cell_stat_t;

endpackage

// ----- design/mrrb_cell.sv -----
// one entry of the reorder chain: holds a request and its response
// depends on mrrb_pkg; instantiated in a row by the top level
`timescale 1ns / 1ps

module mrrb_cell import mrrb_pkg::*; #(
  parameter int SID = ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  entry_t             next_i,
  input  logic [SID-1:0]     next_id_i,
  input  logic [SID-1:0]     req_id_i,
  input  logic [ADDR_W-1:0]  req_addr_i,
  input  logic               req_posted_i,
  input  logic [SID-1:0]     resp_id_i,
  input  logic [DATA_W-1:0]  resp_data_i,
  input  logic [TICK_W-1:0]  resp_ready_i,
  output entry_t             entry_o,
  output logic [SID-1:0]     id_o,
  output cell_stat_t         stat_o
);

  logic              valid_q;
  status_e           status_q;
  logic              posted_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [TICK_W-1:0] ready_q;
  logic [SID-1:0]    id_q;

  // occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= next_i.valid;
    end else if (ctl_i.load) begin
      valid_q <= 1'b1;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      status_q <= next_i.status;
      posted_q <= next_i.posted;
      addr_q   <= next_i.addr;
      data_q   <= next_i.data;
      ready_q  <= next_i.ready_time;
      id_q     <= next_id_i;
    end else if (ctl_i.load) begin
      status_q <= ST_UNSENT;
      posted_q <= req_posted_i;
      addr_q   <= req_addr_i;
      id_q     <= req_id_i;
    end else if (ctl_i.mark_sent) begin
      status_q <= ST_SENT;
    end else if (ctl_i.record) begin
      status_q <= ST_RESPONDED;
      data_q   <= resp_data_i;
      ready_q  <= resp_ready_i;
    end
  end

  // contents toward the older neighbor
  assign entry_o.valid      = valid_q;
  assign entry_o.status     = status_q;
  assign entry_o.posted     = posted_q;
  assign entry_o.addr       = addr_q;
  assign entry_o.data       = data_q;
  assign entry_o.ready_time = ready_q;
  assign id_o               = id_q;

  // local flags
  assign stat_o.valid     = valid_q;
  assign stat_o.unsent    = valid_q && (status_q == ST_UNSENT);
  assign stat_o.sent      = valid_q && (status_q == ST_SENT);
  assign stat_o.responded = valid_q && (status_q == ST_RESPONDED);
  assign stat_o.hit       = valid_q && (id_q == resp_id_i);

endmodule

// ----- design/mrrb_apb.sv -----
// configuration register file: capacity register behind an apb-style port
// depends on mrrb_pkg
`timescale 1ns / 1ps

module mrrb_apb import mrrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  capacity_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             wr_en;

  // write strobe in the access phase, word index decode
  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (wr_en) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(capacity_q);
    end
  end

  assign pready     = 1'b1;
  assign capacity_o = capacity_q;

endmodule

// ----- design/memory_request_reorder_buffer_core.sv -----
// memory request reorder buffer: a chain of entry cells run by a phase sequencer
// a tick item is taken only in idle, then runs four passes over the cell chain
// (issue, accept, return, match) and a push phase that registers the result
// once the output is free; return may shift the whole chain, issue only part of it
// reset: all entries empty, tick count zero, capacity zero (full depth)
// depends on mrrb_pkg, mrrb_cell, mrrb_apb
`timescale 1ns / 1ps

module memory_request_reorder_buffer_core import mrrb_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  // tick input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_valid_i,
  input  logic [ID_W-1:0]    req_id_i,
  input  logic [ADDR_W-1:0]  req_addr_i,
  input  logic               req_posted_i,
  input  logic               down_free_i,
  input  logic               up_free_i,
  input  logic               resp_valid_i,
  input  logic [ID_W-1:0]    resp_id_i,
  input  logic [DATA_W-1:0]  resp_data_i,
  input  logic [DELAY_W-1:0] resp_delay_i,
  // tick result
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               req_accepted_o,
  output logic               issue_valid_o,
  output logic [ID_W-1:0]    issue_id_o,
  output logic [ADDR_W-1:0]  issue_addr_o,
  output logic               issue_posted_o,
  output logic               return_valid_o,
  output logic [ID_W-1:0]    return_id_o,
  output logic [DATA_W-1:0]  return_data_o,
  output logic               resp_error_o
);

  localparam int SID = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int IW  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ISSUE,
    PH_ACCEPT,
    PH_RETURN,
    PH_MATCH,
    PH_PUSH
  } phase_e;

  phase_e state_q;

  // captured tick item
  logic               req_valid_q;
  logic [SID-1:0]     req_id_q;
  logic [ADDR_W-1:0]  req_addr_q;
  logic               req_posted_q;
  logic               down_free_q;
  logic               up_free_q;
  logic               resp_valid_q;
  logic [SID-1:0]     resp_id_q;
  logic [DATA_W-1:0]  resp_data_q;
  logic [DELAY_W-1:0] resp_delay_q;

  // result under construction
  logic               res_accepted_q;
  logic               res_issue_valid_q;
  logic [SID-1:0]     res_issue_id_q;
  logic [ADDR_W-1:0]  res_issue_addr_q;
  logic               res_issue_posted_q;
  logic               res_return_valid_q;
  logic [SID-1:0]     res_return_id_q;
  logic [DATA_W-1:0]  res_return_data_q;
  logic               res_error_q;

  // output register
  logic               out_valid_q;
  logic               out_accepted_q;
  logic               out_issue_valid_q;
  logic [SID-1:0]     out_issue_id_q;
  logic [ADDR_W-1:0]  out_issue_addr_q;
  logic               out_issue_posted_q;
  logic               out_return_valid_q;
  logic [SID-1:0]     out_return_id_q;
  logic [DATA_W-1:0]  out_return_data_q;
  logic               out_error_q;

  logic [TICK_W-1:0]  tick_q;
  logic [CAP_W-1:0]   capacity;

  // cell chain wiring
  entry_t             cell_entry [DEPTH];
  logic [SID-1:0]     cell_id    [DEPTH];
  cell_stat_t         cell_stat  [DEPTH];
  cell_ctl_t          cell_ctl   [DEPTH];
  entry_t             next_entry [DEPTH];
  logic [SID-1:0]     next_id    [DEPTH];

  logic [DEPTH-1:0]   valid_vec;
  logic [DEPTH-1:0]   unsent_vec;
  logic [DEPTH-1:0]   sent_vec;
  logic [DEPTH-1:0]   hit_vec;
  logic [DEPTH-1:0]   issue_oh;
  logic [DEPTH-1:0]   hit_oh;
  logic [DEPTH-1:0]   shift_vec;
  logic [DEPTH-1:0]   load_vec;
  logic [DEPTH-1:0]   mark_vec;
  logic [DEPTH-1:0]   rec_vec;

  logic [SID-1:0]     sel_id;
  logic [ADDR_W-1:0]  sel_addr;
  logic               sel_posted;
  logic               hit_sent;
  logic               do_issue;
  logic [IW-1:0]      cap_idx;
  logic               full;
  logic               do_accept;
  logic [TICK_W-1:0]  head_diff;
  logic               do_return;
  logic               do_record;
  logic [TICK_W-1:0]  resp_ready;
  logic               out_free;

  // configuration registers
  mrrb_apb u_apb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // row of entry cells, each fed by its younger neighbor
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == DEPTH - 1) begin : g_tail
      assign next_entry[k] = '0;
      assign next_id[k]    = '0;
    end else begin : g_link
      assign next_entry[k] = cell_entry[k+1];
      assign next_id[k]    = cell_id[k+1];
    end

    assign cell_ctl[k].shift     = shift_vec[k];
    assign cell_ctl[k].load      = load_vec[k];
    assign cell_ctl[k].mark_sent = mark_vec[k];
    assign cell_ctl[k].record    = rec_vec[k];

    assign valid_vec[k]  = cell_stat[k].valid;
    assign unsent_vec[k] = cell_stat[k].unsent;
    assign sent_vec[k]   = cell_stat[k].sent;
    assign hit_vec[k]    = cell_stat[k].hit;

    mrrb_cell #(
      .SID (SID)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[k]),
      .next_i       (next_entry[k]),
      .next_id_i    (next_id[k]),
      .req_id_i     (req_id_q),
      .req_addr_i   (req_addr_q),
      .req_posted_i (req_posted_q),
      .resp_id_i    (resp_id_q),
      .resp_data_i  (resp_data_q),
      .resp_ready_i (resp_ready),
      .entry_o      (cell_entry[k]),
      .id_o         (cell_id[k]),
      .stat_o       (cell_stat[k])
    );
  end

  // oldest flagged entry by lowest-set-bit isolation
  assign issue_oh = unsent_vec & (~unsent_vec + DEPTH'(1));
  assign hit_oh   = hit_vec & (~hit_vec + DEPTH'(1));

  // fields of the selected entries
  always_comb begin
    sel_id     = '0;
    sel_addr   = '0;
    sel_posted = 1'b0;
    hit_sent   = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      sel_id     = sel_id | ({SID{issue_oh[k]}} & cell_id[k]);
      sel_addr   = sel_addr | ({ADDR_W{issue_oh[k]}} & cell_entry[k].addr);
      sel_posted = sel_posted | (issue_oh[k] & cell_entry[k].posted);
      hit_sent   = hit_sent | (hit_oh[k] & sent_vec[k]);
    end
  end

  // effective capacity as the index of the last usable cell
  always_comb begin
    if (capacity == '0 || 32'(capacity) > DEPTH) begin
      cap_idx = IW'(DEPTH - 1);
    end else begin
      cap_idx = IW'(capacity - CAP_W'(1));
    end
  end

  assign full      = valid_vec[cap_idx];
  assign do_issue  = down_free_q && (unsent_vec != '0);
  assign do_accept = req_valid_q && !full;
  assign head_diff = tick_q - cell_entry[0].ready_time;
  assign do_return = up_free_q && cell_stat[0].responded && !head_diff[TICK_W-1];
  assign do_record = resp_valid_q && (hit_vec != '0) && hit_sent;
  assign resp_ready = tick_q + TICK_W'(1) + TICK_W'(resp_delay_q);

  // per-phase cell actions
  always_comb begin
    shift_vec = '0;
    load_vec  = '0;
    mark_vec  = '0;
    rec_vec   = '0;
    case (state_q)
      PH_ISSUE: begin
        if (do_issue) begin
          if (sel_posted) begin
            shift_vec = ~(issue_oh - DEPTH'(1));
          end else begin
            mark_vec = issue_oh;
          end
        end
      end
      PH_ACCEPT: begin
        for (int k = 0; k < DEPTH; k++) begin
          load_vec[k] = do_accept && !valid_vec[k] && ((k == 0) || valid_vec[(k == 0) ? 0 : k-1]);
        end
      end
      PH_RETURN: begin
        if (do_return) begin
          shift_vec = '1;
        end
      end
      PH_MATCH: begin
        if (do_record) begin
          rec_vec = hit_oh;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer, result assembly and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= PH_IDLE;
      tick_q             <= '0;
      out_valid_q        <= 1'b0;
      req_valid_q        <= 1'b0;
      req_id_q           <= '0;
      req_addr_q         <= '0;
      req_posted_q       <= 1'b0;
      down_free_q        <= 1'b0;
      up_free_q          <= 1'b0;
      resp_valid_q       <= 1'b0;
      resp_id_q          <= '0;
      resp_data_q        <= '0;
      resp_delay_q       <= '0;
      res_accepted_q     <= 1'b0;
      res_issue_valid_q  <= 1'b0;
      res_issue_id_q     <= '0;
      res_issue_addr_q   <= '0;
      res_issue_posted_q <= 1'b0;
      res_return_valid_q <= 1'b0;
      res_return_id_q    <= '0;
      res_return_data_q  <= '0;
      res_error_q        <= 1'b0;
      out_accepted_q     <= 1'b0;
      out_issue_valid_q  <= 1'b0;
      out_issue_id_q     <= '0;
      out_issue_addr_q   <= '0;
      out_issue_posted_q <= 1'b0;
      out_return_valid_q <= 1'b0;
      out_return_id_q    <= '0;
      out_return_data_q  <= '0;
      out_error_q        <= 1'b0;
    end else begin
      // drained result leaves, unless the push phase refills it
      if (out_valid_q && !out_stall_i && (state_q != PH_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        PH_IDLE: begin
          if (in_valid_i) begin
            req_valid_q        <= req_valid_i;
            req_id_q           <= req_id_i[SID-1:0];
            req_addr_q         <= req_addr_i;
            req_posted_q       <= req_posted_i;
            down_free_q        <= down_free_i;
            up_free_q          <= up_free_i;
            resp_valid_q       <= resp_valid_i;
            resp_id_q          <= resp_id_i[SID-1:0];
            resp_data_q        <= resp_data_i;
            resp_delay_q       <= resp_delay_i;
            res_accepted_q     <= 1'b0;
            res_issue_valid_q  <= 1'b0;
            res_issue_id_q     <= '0;
            res_issue_addr_q   <= '0;
            res_issue_posted_q <= 1'b0;
            res_return_valid_q <= 1'b0;
            res_return_id_q    <= '0;
            res_return_data_q  <= '0;
            res_error_q        <= 1'b0;
            state_q            <= PH_ISSUE;
          end
        end
        PH_ISSUE: begin
          if (do_issue) begin
            res_issue_valid_q  <= 1'b1;
            res_issue_id_q     <= sel_id;
            res_issue_addr_q   <= sel_addr;
            res_issue_posted_q <= sel_posted;
          end
          state_q <= PH_ACCEPT;
        end
        PH_ACCEPT: begin
          res_accepted_q <= do_accept;
          state_q        <= PH_RETURN;
        end
        PH_RETURN: begin
          if (do_return) begin
            res_return_valid_q <= 1'b1;
            res_return_id_q    <= cell_id[0];
            res_return_data_q  <= cell_entry[0].data;
          end
          state_q <= PH_MATCH;
        end
        PH_MATCH: begin
          res_error_q <= resp_valid_q && !do_record;
          state_q     <= PH_PUSH;
        end
        PH_PUSH: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_accepted_q     <= res_accepted_q;
            out_issue_valid_q  <= res_issue_valid_q;
            out_issue_id_q     <= res_issue_id_q;
            out_issue_addr_q   <= res_issue_addr_q;
            out_issue_posted_q <= res_issue_posted_q;
            out_return_valid_q <= res_return_valid_q;
            out_return_id_q    <= res_return_id_q;
            out_return_data_q  <= res_return_data_q;
            out_error_q        <= res_error_q;
            tick_q             <= tick_q + TICK_W'(1);
            state_q            <= PH_IDLE;
          end
        end
        default: begin
          state_q <= PH_IDLE;
        end
      endcase
    end
  end

  // port drive
  assign in_stall_o     = (state_q != PH_IDLE);
  assign out_valid_o    = out_valid_q;
  assign req_accepted_o = out_accepted_q;
  assign issue_valid_o  = out_issue_valid_q;
  assign issue_id_o     = ID_W'(out_issue_id_q);
  assign issue_addr_o   = out_issue_addr_q;
  assign issue_posted_o = out_issue_posted_q;
  assign return_valid_o = out_return_valid_q;
  assign return_id_o    = ID_W'(out_return_id_q);
  assign return_data_o  = out_return_data_q;
  assign resp_error_o   = out_error_q;

`ifndef SYNTH
  // occupied cells stay packed at the head of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("reorder chain has a hole");

  // at most one cell takes a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(load_vec))
    else $error("more than one cell loaded");

  // at most one entry is marked sent, and at most one records a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(mark_vec) && $onehot0(rec_vec))
    else $error("several cells updated at once");

  // a result appears only after the last phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == PH_PUSH))
    else $error("result pushed outside the push phase");
`endif

endmodule
